/* rtl/fsr_pkg.sv */
// Package with the request and result types and constants of the float split and round block.
package fsr_pkg;

	localparam logic [1:0] KIND_FREXP = 2'd0;
	localparam logic [1:0] KIND_MODF  = 2'd1;
	localparam logic [1:0] KIND_FLOOR = 2'd2;
	localparam logic [1:0] KIND_CEIL  = 2'd3;

	localparam logic [10:0] EXP_MAX  = 11'h7FF;
	localparam logic [10:0] EXP_HALF = 11'h3FE;
	localparam logic [10:0] EXP_ONE  = 11'h3FF;
	localparam logic [10:0] EXP_BIAS = 11'd1023;

	typedef struct packed {
		logic [1:0]  kind;
		logic [63:0] operand_bits;
	} req_t;

	typedef struct packed {
		logic [63:0]       main_bits;
		logic [63:0]       integer_part_bits;
		logic signed [11:0] binary_exponent;
	} res_t;

	// Decoded operand carried from the first stage.
	typedef struct packed {
		logic [1:0]  kind;
		logic [63:0] x;
		logic        is_special;
		logic        is_zero;
		logic        below_one;
		logic        integral;
		logic [52:0] mask;
		logic [5:0]  shamt;
	} dec_t;

	// Priority search for the highest set bit in a 53-bit word.
	function automatic logic [5:0] top_bit(input logic [52:0] v);
		logic [5:0] p;
		p = '0;
		for (int i = 0; i < 53; i++) begin
			if (v[i]) p = 6'(i);
		end
		return p;
	endfunction

endpackage

/* rtl/fsr_decode.sv */
// First pipeline stage: field decode and generation of the fraction mask for modf, floor and ceil.
module fsr_decode (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          vin,
	input  fsr_pkg::req_t req,
	output logic          vout,
	output fsr_pkg::dec_t dec
);
	logic [10:0] bexp;
	logic [51:0] frac;
	logic [11:0] e;
	fsr_pkg::dec_t d;

	always_comb begin
		bexp = req.operand_bits[62:52];
		frac = req.operand_bits[51:0];
		e = {1'b0, bexp} - {1'b0, fsr_pkg::EXP_BIAS};
		d.kind = req.kind;
		d.x = req.operand_bits;
		d.is_special = (bexp == fsr_pkg::EXP_MAX);
		d.is_zero = (bexp == '0) && (frac == '0);
		d.below_one = (bexp < fsr_pkg::EXP_BIAS);
		d.integral = !d.below_one && (e >= 12'd52);
		d.shamt = d.integral || d.below_one ? 6'd0 : 6'(12'd52 - e);
		d.mask = (53'd1 << d.shamt) - 53'd1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vout <= 1'b0;
		else if (en) vout <= vin;
	end

	always_ff @(posedge clk) begin
		if (en) dec <= d;
	end
endmodule

/* rtl/fsr_search.sv */
// Second pipeline stage: leading-one search on the fraction or subnormal field.
module fsr_search (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          vin,
	input  fsr_pkg::dec_t dec,
	output logic          vout,
	output fsr_pkg::dec_t dec_o,
	output logic [52:0]   f_o,
	output logic [5:0]    p_o
);
	logic [52:0] f;

	always_comb begin
		if (dec.kind == fsr_pkg::KIND_FREXP) f = {1'b0, dec.x[51:0]};
		else f = {1'b0, dec.x[51:0]} & dec.mask;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vout <= 1'b0;
		else if (en) vout <= vin;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dec_o <= dec;
			f_o <= f;
			p_o <= fsr_pkg::top_bit(f);
		end
	end
endmodule

/* rtl/fsr_assemble.sv */
// Third and fourth stages: shift, assemble and the floor or ceil increment.
module fsr_assemble (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          vin,
	input  fsr_pkg::dec_t dec,
	input  logic [52:0]   f,
	input  logic [5:0]    p,
	output logic          vout,
	output fsr_pkg::res_t res
);
	logic        sign;
	logic [10:0] bexp;
	logic [63:0] ip, fp, mainv;
	logic [52:0] fs;
	logic        has_frac;
	logic [11:0] expo;
	logic [11:0] fe;
	logic [63:0] ip_s3;
	logic [63:0] main_s3;
	logic [11:0] expo_s3;
	logic [5:0]  shamt_s3;
	logic        up_s3, below_s3, v_s3;
	logic [1:0]  kind_s3;
	logic [63:0] mag;

	always_comb begin
		sign = dec.x[63];
		bexp = dec.x[62:52];
		fs = f << (6'd52 - p);
		has_frac = 1'b0;
		expo = '0;
		ip = '0;
		fp = '0;
		mainv = dec.x;
		fe = '0;
		if (dec.kind == fsr_pkg::KIND_FREXP) begin
			if (!dec.is_special && !dec.is_zero) begin
				if (bexp == '0) begin
					mainv = {sign, fsr_pkg::EXP_HALF, fs[51:0]};
					expo = {6'd0, p} - 12'd1073;
				end else begin
					mainv = {sign, fsr_pkg::EXP_HALF, dec.x[51:0]};
					expo = {1'b0, bexp} - 12'd1022;
				end
			end
		end else begin
			if (dec.is_special) begin
				ip = dec.x;
				fp = (dec.x[51:0] != '0) ? dec.x : {sign, 63'd0};
			end else if (dec.below_one) begin
				ip = {sign, 63'd0};
				fp = dec.x;
				has_frac = dec.x[62:0] != '0;
			end else if (dec.integral) begin
				ip = dec.x;
				fp = {sign, 63'd0};
			end else begin
				ip = dec.x & ~{11'd0, dec.mask};
				if (f == '0) fp = {sign, 63'd0};
				else begin
					has_frac = 1'b1;
					// Exponent of the fraction: e - 52 + p + 1023 = 1023 - shamt + p.
					fe = {1'b0, fsr_pkg::EXP_BIAS} - {6'd0, dec.shamt} + {6'd0, p};
					fp = {sign, fe[10:0], fs[51:0]};
				end
			end
			mainv = fp;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			vout <= 1'b0;
		end else if (en) begin
			v_s3 <= vin;
			vout <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			kind_s3 <= dec.kind;
			ip_s3 <= ip;
			main_s3 <= mainv;
			expo_s3 <= expo;
			shamt_s3 <= dec.shamt;
			below_s3 <= dec.below_one;
			up_s3 <= !dec.is_special && has_frac &&
				((dec.kind == fsr_pkg::KIND_FLOOR && sign) ||
				 (dec.kind == fsr_pkg::KIND_CEIL && !sign));
		end
	end

	// Adding one unit at the lowest integer bit may carry into the exponent, which is exact.
	always_comb begin
		mag = {1'b0, ip_s3[62:0]} + (64'd1 << shamt_s3);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res.binary_exponent <= expo_s3;
			res.integer_part_bits <= (kind_s3 == fsr_pkg::KIND_MODF) ? ip_s3 : '0;
			case (kind_s3)
				fsr_pkg::KIND_FREXP, fsr_pkg::KIND_MODF: res.main_bits <= main_s3;
				default: begin
					if (!up_s3) res.main_bits <= ip_s3;
					else if (below_s3) res.main_bits <= {ip_s3[63], fsr_pkg::EXP_ONE, 52'd0};
					else res.main_bits <= {ip_s3[63], mag[62:0]};
				end
			endcase
		end
	end
endmodule

/* rtl/float_split_and_round.sv */
// Top level of the float split and round block.
// Each request gives one result after it is accepted; a request may be accepted in every cycle,
// so busy stays low. The four register stages are decode, leading-one search, shift and assembly,
// and the floor or ceil increment. The result strobe marks one cycle.
module float_split_and_round (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  fsr_pkg::req_t req,
	output logic          done,
	output fsr_pkg::res_t res
);
	logic          v1, v2;
	fsr_pkg::dec_t d1, d2;
	logic [52:0]   f2;
	logic [5:0]    p2;

	assign busy = 1'b0;

	fsr_decode u_dec (
		.clk(clk), .arst_n(arst_n), .en(1'b1), .vin(start), .req(req),
		.vout(v1), .dec(d1)
	);

	fsr_search u_srch (
		.clk(clk), .arst_n(arst_n), .en(1'b1), .vin(v1), .dec(d1),
		.vout(v2), .dec_o(d2), .f_o(f2), .p_o(p2)
	);

	fsr_assemble u_asm (
		.clk(clk), .arst_n(arst_n), .en(1'b1), .vin(v2), .dec(d2), .f(f2), .p(p2),
		.vout(done), .res(res)
	);
endmodule
